[rtl/core/clr_pkg.sv]
// Shared widths, limits and register codes for the clipped line rasterizer.
// No dependencies; used by the channel interfaces and the top level.
package clr_pkg;

   // field widths
   localparam int CMD_W   = 16;
   localparam int COORD_W = 6;
   localparam int DIM_W   = 7;
   localparam int ADDR_W  = 12;
   localparam int GRAY_W  = 8;
   localparam int ERR_W   = 8;
   localparam int LEFT_W  = 7;

   // largest frame side in pixels
   localparam logic [DIM_W-1:0] MAX_DIM = 7'd64;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef logic signed [CMD_W-1:0] cmd_coord_type;
   typedef logic [COORD_W-1:0]      coord_type;

endpackage

[rtl/core/clr_req_if.sv]
// Line command channel: valid/ready handshake with two endpoints and a gray level.
// Depends on clr_pkg.
interface clr_req_if;
   logic                         valid;
   logic                         ready;
   clr_pkg::cmd_coord_type       start_x;
   clr_pkg::cmd_coord_type       start_y;
   clr_pkg::cmd_coord_type       end_x;
   clr_pkg::cmd_coord_type       end_y;
   logic [clr_pkg::GRAY_W-1:0]   gray_value;

   modport source (output valid, start_x, start_y, end_x, end_y, gray_value,
                   input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, gray_value,
                 output ready);
endinterface

[rtl/core/clr_rsp_if.sv]
// Pixel write channel: valid/ready handshake with position, address and gray level.
// Depends on clr_pkg.
interface clr_rsp_if;
   logic                         valid;
   logic                         ready;
   clr_pkg::coord_type           pixel_x;
   clr_pkg::coord_type           pixel_y;
   logic [clr_pkg::ADDR_W-1:0]   pixel_addr;
   logic [clr_pkg::GRAY_W-1:0]   pixel_value;
   logic                         last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_addr, pixel_value, last_pixel,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_addr, pixel_value, last_pixel,
                 output ready);
endinterface

[rtl/core/clipped_line_rasterizer.sv]
// Sequence: a command transfer is followed by a clamp pass over the four coordinates and a
// setup step, after which the walk loads the first pixel into the output register.
// Throughput: one pixel per cycle while the sink is ready; the next command can transfer in
// the cycle after the last pixel is registered, since the sequencer returns to idle then; no
// command is taken while a line is being clamped, set up or walked.
// Reset: synchronous, active high; clears the sequencer and output valid, frame size to 64.
module clipped_line_rasterizer (
   input  logic                              clock,
   input  logic                              reset,
   clr_req_if.sink                           req_if,
   clr_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [clr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [clr_pkg::DIM_W-1:0]         csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CLAMP = 2'd1;
   localparam logic [1:0] ST_SETUP = 2'd2;
   localparam logic [1:0] ST_WALK  = 2'd3;

   localparam int SUM_W = clr_pkg::COORD_W + clr_pkg::DIM_W + 1;

   logic [1:0]                      state_ff, state_in;
   logic [1:0]                      idx_ff, idx_in;
   logic [clr_pkg::DIM_W-1:0]       width_ff, height_ff;
   clr_pkg::cmd_coord_type          raw_ff [4];
   clr_pkg::coord_type              clamp_ff [4];
   logic [clr_pkg::GRAY_W-1:0]      color_ff;
   clr_pkg::coord_type              walk_x_ff, walk_x_in;
   clr_pkg::coord_type              walk_y_ff, walk_y_in;
   logic signed [clr_pkg::ERR_W-1:0] err_ff, err_in;
   clr_pkg::coord_type              major_ff, minor_ff;
   logic [1:0]                      sign_ff;
   logic                            x_major_ff;
   logic [clr_pkg::LEFT_W-1:0]      left_ff, left_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   clr_pkg::coord_type              out_x_ff, out_y_ff;
   logic [clr_pkg::ADDR_W-1:0]      out_addr_ff;
   logic [clr_pkg::GRAY_W-1:0]      out_value_ff;
   logic                            out_last_ff;

   logic [clr_pkg::DIM_W-1:0]       w_eff, h_eff, limit;
   clr_pkg::cmd_coord_type          clamp_src;
   clr_pkg::coord_type              clamp_res;
   logic                            req_xfer, load;

   // effective frame size: zero acts as one, oversize acts as the maximum
   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = clr_pkg::DIM_W'(1);
      end else if (width_ff > clr_pkg::MAX_DIM) begin
         w_eff = clr_pkg::MAX_DIM;
      end
      h_eff = height_ff;
      if (height_ff == '0) begin
         h_eff = clr_pkg::DIM_W'(1);
      end else if (height_ff > clr_pkg::MAX_DIM) begin
         h_eff = clr_pkg::MAX_DIM;
      end
   end

   assign req_xfer = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign load = (state_ff == ST_WALK) && (!rsp_valid_ff || rsp_if.ready);

   // shared clamp unit, one coordinate per cycle: even slots are columns
   always_comb begin
      clamp_src = raw_ff[idx_ff];
      limit = idx_ff[0] ? h_eff : w_eff;
      if (clamp_src[clr_pkg::CMD_W-1]) begin
         clamp_res = '0;
      end else if (clamp_src[clr_pkg::CMD_W-2:0] >= (clr_pkg::CMD_W-1)'(limit)) begin
         clamp_res = clr_pkg::COORD_W'(limit - clr_pkg::DIM_W'(1));
      end else begin
         clamp_res = clamp_src[clr_pkg::COORD_W-1:0];
      end
   end

   // one walk step: error update decides whether the minor axis moves
   logic signed [clr_pkg::ERR_W-1:0] err_sum;
   logic                             step_minor, step_x, step_y;
   logic [SUM_W-1:0]                 addr_full;

   always_comb begin
      err_sum = err_ff + $signed({2'b00, minor_ff});
      step_minor = !err_sum[clr_pkg::ERR_W-1] && (err_sum != '0);
      err_in = step_minor ? err_sum - $signed({2'b00, major_ff}) : err_sum;
      step_x = x_major_ff || step_minor;
      step_y = !x_major_ff || step_minor;
      walk_x_in = walk_x_ff;
      if (step_x) begin
         walk_x_in = sign_ff[0] ? walk_x_ff - 1'b1 : walk_x_ff + 1'b1;
      end
      walk_y_in = walk_y_ff;
      if (step_y) begin
         walk_y_in = sign_ff[1] ? walk_y_ff - 1'b1 : walk_y_ff + 1'b1;
      end
      left_in = left_ff - 1'b1;
      addr_full = SUM_W'(walk_y_ff) * SUM_W'(w_eff) + SUM_W'(walk_x_ff);
   end

   // setup: deltas, step directions and major axis from the clamped endpoints
   clr_pkg::coord_type dx, dy, major, minor;
   logic               sx_neg, sy_neg, x_major;

   always_comb begin
      sx_neg = !(clamp_ff[0] < clamp_ff[2]);
      sy_neg = !(clamp_ff[1] < clamp_ff[3]);
      dx = sx_neg ? clamp_ff[0] - clamp_ff[2] : clamp_ff[2] - clamp_ff[0];
      dy = sy_neg ? clamp_ff[1] - clamp_ff[3] : clamp_ff[3] - clamp_ff[1];
      x_major = (dx >= dy);
      major = x_major ? dx : dy;
      minor = x_major ? dy : dx;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_xfer) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 2'd3) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (load && left_ff == clr_pkg::LEFT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers and frame size
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff <= clr_pkg::MAX_DIM;
         height_ff <= clr_pkg::MAX_DIM;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == clr_pkg::CSR_FRAME_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_we && csr_index == clr_pkg::CSR_FRAME_HEIGHT) begin
            height_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         raw_ff[0] <= req_if.start_x;
         raw_ff[1] <= req_if.start_y;
         raw_ff[2] <= req_if.end_x;
         raw_ff[3] <= req_if.end_y;
         color_ff <= req_if.gray_value;
      end
      if (state_ff == ST_CLAMP) begin
         clamp_ff[idx_ff] <= clamp_res;
      end
      if (state_ff == ST_SETUP) begin
         walk_x_ff <= clamp_ff[0];
         walk_y_ff <= clamp_ff[1];
         sign_ff <= {sy_neg, sx_neg};
         x_major_ff <= x_major;
         major_ff <= major;
         minor_ff <= minor;
         err_ff <= -$signed({3'b000, major[clr_pkg::COORD_W-1:1]});
         left_ff <= {1'b0, major} + 1'b1;
      end
      if (load) begin
         out_x_ff <= walk_x_ff;
         out_y_ff <= walk_y_ff;
         out_addr_ff <= addr_full[clr_pkg::ADDR_W-1:0];
         out_value_ff <= color_ff;
         out_last_ff <= (left_ff == clr_pkg::LEFT_W'(1));
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         err_ff <= err_in;
         left_ff <= left_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.pixel_x = out_x_ff;
   assign rsp_if.pixel_y = out_y_ff;
   assign rsp_if.pixel_addr = out_addr_ff;
   assign rsp_if.pixel_value = out_value_ff;
   assign rsp_if.last_pixel = out_last_ff;

   // a walk never runs with nothing left to emit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (left_ff != '0))
      else $error("walk active with no pixels left");

   // a command transfer starts the clamp pass at the first coordinate
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_CLAMP) && (idx_ff == 2'd0))
      else $error("command transfer did not start clamping");

   // loading the final pixel ends the line and flags it
   assert property (@(posedge clock) disable iff (reset)
      (load && left_ff == clr_pkg::LEFT_W'(1)) |=>
         (state_ff == ST_IDLE) && rsp_valid_ff && out_last_ff)
      else $error("final pixel not flagged or line not ended");

endmodule
